[design/kcu_pkg.sv]
// Package for the k-means centroid update core: field widths, command and
// register codes, divider job and result types. No dependencies.
`default_nettype none

package kcu_pkg;

    localparam int KCU_MAX_CLUSTERS   = 16;
    localparam int KCU_MAX_DIMENSIONS = 16;

    localparam int IDX_W   = 4;   // cluster and coordinate index fields
    localparam int VALUE_W = 32;  // Q16.16 coordinate and mean
    localparam int SUM_W   = 52;  // per-dimension running sum
    localparam int COUNT_W = 20;  // per-cluster point count
    localparam int CFG_W   = 5;   // configuration register width
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MEAN_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] MEAN_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Commands carried in tuser
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CLUSTERS   = 1'b0;
    localparam logic CFG_DIMENSIONS = 1'b1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]        cluster;
        logic [IDX_W-1:0]        coord;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
        logic                    empty;
    } kcu_job_t;

    typedef struct packed {
        logic [IDX_W-1:0]          cluster;
        logic [IDX_W-1:0]          coord;
        logic signed [VALUE_W-1:0] mean;
        logic                      empty;
    } kcu_result_t;

endpackage

`default_nettype wire

[design/kmeans_centroid_update_core.sv]
// Lloyd k-means centroid update core (sum and count stores, mean divider).
// Accumulate transactions: one per cycle while s_tready is high, no result; two-stage read-modify-write.
// Read transactions: one result each, from the 52-step bit-serial divider (skipped when
// the mean is empty); the next transaction waits until the divider hands its result on.
// Reset: clearing pass over all MAX_CLUSTERS*MAX_DIMENSIONS sum entries, s_tready low.
// Depends on kcu_pkg, kcu_ram and kcu_div.
`default_nettype none

module kmeans_centroid_update_core #(
    parameter int MAX_CLUSTERS   = kcu_pkg::KCU_MAX_CLUSTERS,
    parameter int MAX_DIMENSIONS = kcu_pkg::KCU_MAX_DIMENSIONS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [kcu_pkg::CFG_W-1:0]   cfg_data,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,  // cluster_index, coord_index, coord_value
    input  wire logic                        s_tuser,  // cmd
    input  wire logic                        s_tlast,  // point_done
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [39:0]                      m_tdata,  // out_cluster, out_coord, mean_value
    output logic                             m_tuser   // empty_cluster
);

    import kcu_pkg::*;

    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMENSIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAW   = $clog2(MAX_CLUSTERS);

    // Configuration
    logic [CFG_W-1:0] cfg_clusters_reg;
    logic [CFG_W-1:0] cfg_dims_reg;

    // Clearing pass after reset
    logic          clear_busy_reg;
    logic [AW-1:0] clear_addr_reg;

    // Input decode
    logic [IDX_W-1:0]          in_cluster;
    logic [IDX_W-1:0]          in_coord;
    logic signed [VALUE_W-1:0] in_value;
    logic                      in_cl_ok;
    logic                      in_dim_ok;
    logic                      in_last_dim;
    logic [AW-1:0]             in_addr;
    logic [CAW-1:0]            in_caddr;
    logic                      accept;

    // Second stage: memory data is back, modify and write
    logic                      b_valid_reg;
    logic                      b_cmd_reg;
    logic                      b_inside_reg;
    logic                      b_last_dim_reg;
    logic                      b_done_reg;
    logic signed [VALUE_W-1:0] b_value_reg;
    logic [IDX_W-1:0]          b_cluster_reg;
    logic [IDX_W-1:0]          b_coord_reg;
    logic [AW-1:0]             b_addr_reg;
    logic [CAW-1:0]            b_caddr_reg;

    // Bypass of the write made at the edge of the read
    logic                      fw_sum_valid_reg;
    logic [AW-1:0]             fw_sum_addr_reg;
    logic signed [SUM_W-1:0]   fw_sum_data_reg;
    logic                      fw_cnt_valid_reg;
    logic [CAW-1:0]            fw_cnt_addr_reg;
    logic [COUNT_W-1:0]        fw_cnt_data_reg;

    // Memory ports
    logic                      sum_we;
    logic [AW-1:0]             sum_waddr;
    logic signed [SUM_W-1:0]   sum_wdata;
    logic [SUM_W-1:0]          sum_rdata;
    logic                      cnt_we;
    logic [CAW-1:0]            cnt_waddr;
    logic [COUNT_W-1:0]        cnt_wdata;
    logic [COUNT_W-1:0]        cnt_rdata;

    // Modify logic
    logic signed [SUM_W-1:0]   cur_sum;
    logic [COUNT_W-1:0]        cur_cnt;
    logic signed [SUM_W:0]     add_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [COUNT_W-1:0]        cnt_inc;
    logic                      b_sum_we;
    logic signed [SUM_W-1:0]   b_sum_wdata;
    logic                      b_cnt_we;
    logic [COUNT_W-1:0]        b_cnt_wdata;

    // Divider and output register
    logic                      div_start;
    kcu_job_t                  div_job;
    logic                      div_idle;
    logic                      div_res_valid;
    logic                      div_res_ready;
    kcu_result_t               div_res;
    logic                      out_valid_reg;
    kcu_result_t               out_res_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_clusters_reg <= CFG_W'(16);
            cfg_dims_reg     <= CFG_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLUSTERS:   cfg_clusters_reg <= cfg_data;
                CFG_DIMENSIONS: cfg_dims_reg     <= cfg_data;
                default:        cfg_clusters_reg <= cfg_clusters_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass: zero one sum entry (and count entry) per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clear_addr_reg == AW'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input decode. A register value of zero acts as one and a value
    // above the maximum acts as the maximum.
    // ------------------------------------------------------------------
    assign in_cluster = s_tdata[3:0];
    assign in_coord   = s_tdata[7:4];
    assign in_value   = signed'(s_tdata[39:8]);

    assign in_cl_ok = (32'(in_cluster) < MAX_CLUSTERS)
                   && (({1'b0, in_cluster} < cfg_clusters_reg)
                       || ((cfg_clusters_reg == '0) && (in_cluster == '0)));
    assign in_dim_ok = (32'(in_coord) < MAX_DIMENSIONS)
                    && (({1'b0, in_coord} < cfg_dims_reg)
                        || ((cfg_dims_reg == '0) && (in_coord == '0)));

    always_comb
    begin
        if (cfg_dims_reg == '0)
        begin
            in_last_dim = (in_coord == '0);
        end
        else if (32'(cfg_dims_reg) > MAX_DIMENSIONS)
        begin
            in_last_dim = (32'(in_coord) == MAX_DIMENSIONS - 1);
        end
        else
        begin
            in_last_dim = ((32'(in_coord) + 32'd1) == 32'(cfg_dims_reg));
        end
    end

    assign in_addr  = AW'(32'(in_cluster) * MAX_DIMENSIONS + 32'(in_coord));
    assign in_caddr = CAW'(in_cluster);

    // Hold off while clearing, while a read is in the modify stage or the divider
    assign s_tready = ~clear_busy_reg & div_idle & ~(b_valid_reg & (b_cmd_reg == CMD_READ));
    assign accept   = s_tvalid & s_tready;

    // ------------------------------------------------------------------
    // Stage B registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg      <= 1'b0;
            fw_sum_valid_reg <= 1'b0;
            fw_cnt_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg      <= accept;
            fw_sum_valid_reg <= b_sum_we;
            fw_cnt_valid_reg <= b_cnt_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cmd_reg      <= s_tuser;
            b_inside_reg   <= in_cl_ok & in_dim_ok;
            b_last_dim_reg <= in_last_dim;
            b_done_reg     <= s_tlast;
            b_value_reg    <= in_value;
            b_cluster_reg  <= in_cluster;
            b_coord_reg    <= in_coord;
            b_addr_reg     <= in_addr;
            b_caddr_reg    <= in_caddr;
        end
        fw_sum_addr_reg <= b_addr_reg;
        fw_sum_data_reg <= b_sum_wdata;
        fw_cnt_addr_reg <= b_caddr_reg;
        fw_cnt_data_reg <= b_cnt_wdata;
    end

    // ------------------------------------------------------------------
    // Modify: take bypassed data when the previous transaction just wrote
    // the same entry, then saturate the sum and count.
    // ------------------------------------------------------------------
    assign cur_sum = (fw_sum_valid_reg && (fw_sum_addr_reg == b_addr_reg))
                   ? fw_sum_data_reg : signed'(sum_rdata);
    assign cur_cnt = (fw_cnt_valid_reg && (fw_cnt_addr_reg == b_caddr_reg))
                   ? fw_cnt_data_reg : cnt_rdata;

    assign add_wide = {cur_sum[SUM_W-1], cur_sum}
                    + {{(SUM_W + 1 - VALUE_W){b_value_reg[VALUE_W-1]}}, b_value_reg};

    always_comb
    begin
        if (add_wide[SUM_W] != add_wide[SUM_W-1])
        begin
            sum_sat = add_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = add_wide[SUM_W-1:0];
        end
    end

    assign cnt_inc = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);

    // Accumulate adds; read clears the sum, and the count on the last dimension
    assign b_sum_we    = b_valid_reg & b_inside_reg;
    assign b_sum_wdata = (b_cmd_reg == CMD_ACCUMULATE) ? sum_sat : '0;
    assign b_cnt_we    = b_valid_reg & b_inside_reg
                       & (((b_cmd_reg == CMD_ACCUMULATE) & b_done_reg)
                          | ((b_cmd_reg == CMD_READ) & b_last_dim_reg));
    assign b_cnt_wdata = (b_cmd_reg == CMD_ACCUMULATE) ? cnt_inc : '0;

    // Memory write ports: clearing pass or stage B
    always_comb
    begin
        if (clear_busy_reg)
        begin
            sum_we    = 1'b1;
            sum_waddr = clear_addr_reg;
            sum_wdata = '0;
            cnt_we    = (32'(clear_addr_reg) < MAX_CLUSTERS);
            cnt_waddr = CAW'(clear_addr_reg);
            cnt_wdata = '0;
        end
        else
        begin
            sum_we    = b_sum_we;
            sum_waddr = b_addr_reg;
            sum_wdata = b_sum_wdata;
            cnt_we    = b_cnt_we;
            cnt_waddr = b_caddr_reg;
            cnt_wdata = b_cnt_wdata;
        end
    end

    kcu_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (in_addr),
        .rdata (sum_rdata)
    );

    kcu_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (in_caddr),
        .rdata (cnt_rdata)
    );

    // ------------------------------------------------------------------
    // Divider: a read outside the clusters or dimensions in use, or of an
    // empty cluster, skips the division and reports mean zero.
    // ------------------------------------------------------------------
    assign div_start       = b_valid_reg & (b_cmd_reg == CMD_READ);
    assign div_job.cluster = b_cluster_reg;
    assign div_job.coord   = b_coord_reg;
    assign div_job.sum     = cur_sum;
    assign div_job.count   = cur_cnt;
    assign div_job.empty   = ~b_inside_reg | (cur_cnt == '0);

    kcu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .job       (div_job),
        .idle      (div_idle),
        .res_valid (div_res_valid),
        .res_ready (div_res_ready),
        .res       (div_res)
    );

    // ------------------------------------------------------------------
    // Output register: advance when empty or being drained
    // ------------------------------------------------------------------
    assign div_res_ready = ~out_valid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_res_valid && div_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_res_valid && div_res_ready)
        begin
            out_res_reg <= div_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.mean, out_res_reg.coord, out_res_reg.cluster};
    assign m_tuser  = out_res_reg.empty;

endmodule

`default_nettype wire

[design/kcu_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the sum and count stores of the centroid update core.
`default_nettype none

module kcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/kcu_div.sv]
// Radix-2 restoring divider for the mean: signed sum over unsigned count,
// truncated toward zero and clamped to 32 bits. Depends on kcu_pkg.
`default_nettype none

module kcu_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire kcu_pkg::kcu_job_t    job,
    output logic                      idle,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output kcu_pkg::kcu_result_t      res
);

    import kcu_pkg::*;

    div_state_t             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [COUNT_W-1:0]     divisor_reg, divisor_next;
    logic                   neg_reg, neg_next;
    logic                   empty_reg, empty_next;
    logic [IDX_W-1:0]       cluster_reg, cluster_next;
    logic [IDX_W-1:0]       coord_reg, coord_next;

    logic [COUNT_W:0]       shifted;
    logic [COUNT_W:0]       diff;
    logic                   fits;
    logic [SUM_W-1:0]       sum_mag;
    logic                   ovf_pos;
    logic                   ovf_neg;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};
    assign sum_mag = job.sum[SUM_W-1] ? (~job.sum + SUM_W'(1)) : job.sum;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        empty_next   = empty_reg;
        cluster_next = cluster_reg;
        coord_next   = coord_reg;

        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    cluster_next = job.cluster;
                    coord_next   = job.coord;
                    empty_next   = job.empty;
                    divisor_next = job.count;
                    neg_next     = job.sum[SUM_W-1] & ~job.empty;
                    rem_next     = '0;
                    step_next    = '0;
                    quo_next     = job.empty ? '0 : sum_mag;
                    state_next   = job.empty ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                // one quotient bit per cycle, MSB first
                rem_next  = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (res_ready)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        empty_reg   <= empty_next;
        cluster_reg <= cluster_next;
        coord_reg   <= coord_next;
    end

    // Clamp the magnitude into the 32-bit signed range
    assign ovf_pos = |quo_reg[SUM_W-1:VALUE_W-1];
    assign ovf_neg = (|quo_reg[SUM_W-1:VALUE_W])
                   | (quo_reg[VALUE_W-1] & (|quo_reg[VALUE_W-2:0]));

    always_comb
    begin
        res.cluster = cluster_reg;
        res.coord   = coord_reg;
        res.empty   = empty_reg;
        if (neg_reg)
        begin
            res.mean = ovf_neg ? MEAN_MIN : -signed'(quo_reg[VALUE_W-1:0]);
        end
        else
        begin
            res.mean = ovf_pos ? MEAN_MAX : signed'(quo_reg[VALUE_W-1:0]);
        end
    end

    assign idle      = (state_reg == DIV_IDLE);
    assign res_valid = (state_reg == DIV_DONE);

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for kmeans_centroid_update_core: streams accumulate and
// read transactions, predicts every centroid mean and checks each result.
// Depends on kcu_pkg and the core RTL.

module tb_top;
    import kcu_pkg::*;

    localparam int SETTLE_CYCLES = 64;    // longest read latency plus margin
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction before giving up
    localparam int FEED_DEPTH    = 256;   // cap on queued stimulus

    // One input transaction as the stimulus side sees it
    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          cluster;
        logic [IDX_W-1:0]          coord;
        logic signed [VALUE_W-1:0] value;
        logic                      done;
    } coord_item_t;

    logic clk;
    logic rst_n = 1'b0;

    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_CLUSTERS;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // cluster_index, coord_index, coord_value
    logic        s_tuser  = CMD_ACCUMULATE;  // cmd
    logic        s_tlast  = 1'b0;  // point_done
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;  // out_cluster, out_coord, mean_value
    logic        m_tuser;  // empty_cluster

    // Shadow copy of the sum and count stores and of the two registers
    logic signed [SUM_W-1:0] sum_store [KCU_MAX_CLUSTERS*KCU_MAX_DIMENSIONS];
    logic [COUNT_W-1:0]      point_store [KCU_MAX_CLUSTERS];
    logic [CFG_W-1:0]        k_reg = 5'd16;
    logic [CFG_W-1:0]        d_reg = 5'd16;

    coord_item_t coord_feed [$];      // stimulus waiting for the driver
    kcu_result_t expected_means [$];  // means predicted, not yet seen
    coord_item_t in_flight;

    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    int error_count      = 0;
    int useful_items     = 0;
    int accepted_items   = 0;
    int means_checked    = 0;
    int settings_written = 0;
    int quiet_cycles     = 0;

    kmeans_centroid_update_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp a register value into 1..top, the way the core treats it
    function automatic int in_use(input logic [CFG_W-1:0] v, input int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    // Apply one accepted transaction to the shadow stores; queue a mean on a read
    function automatic void predict_centroid(input coord_item_t it);
        int          k_eff;
        int          d_eff;
        int          slot;
        bit          in_range;
        longint      acc;
        longint      quot;
        kcu_result_t res;
        k_eff    = in_use(k_reg, KCU_MAX_CLUSTERS);
        d_eff    = in_use(d_reg, KCU_MAX_DIMENSIONS);
        in_range = (it.cluster < k_eff) && (it.coord < d_eff);
        slot     = it.cluster * KCU_MAX_DIMENSIONS + it.coord;
        accepted_items++;
        if (it.cmd == CMD_ACCUMULATE)
        begin
            // out-of-range accumulates leave sum and count alone
            if (in_range)
            begin
                acc = longint'(sum_store[slot]) + longint'(it.value);
                if (acc > longint'(SUM_MAX))
                    acc = longint'(SUM_MAX);
                else if (acc < longint'(SUM_MIN))
                    acc = longint'(SUM_MIN);
                sum_store[slot] = acc[SUM_W-1:0];
                if (it.done && point_store[it.cluster] != COUNT_MAX)
                    point_store[it.cluster] = point_store[it.cluster] + 1'b1;
            end
        end
        else
        begin
            res.cluster = it.cluster;
            res.coord   = it.coord;
            res.mean    = '0;
            res.empty   = 1'b1;
            if (in_range)
            begin
                if (point_store[it.cluster] != 0)
                begin
                    // signed division truncates toward zero
                    quot = longint'(sum_store[slot]) / longint'(point_store[it.cluster]);
                    if (quot > longint'(MEAN_MAX))
                        quot = longint'(MEAN_MAX);
                    else if (quot < longint'(MEAN_MIN))
                        quot = longint'(MEAN_MIN);
                    res.mean  = quot[VALUE_W-1:0];
                    res.empty = 1'b0;
                end
                sum_store[slot] = '0;
                if (it.coord == d_eff - 1)
                    point_store[it.cluster] = '0;
            end
            expected_means.insert(expected_means.size(), res);
        end
    endfunction

    // Input driver: advance to the next queued item whenever the slot is free
    always @(posedge clk or negedge rst_n)
    begin : coord_driver
        coord_item_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_ACCUMULATE;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_centroid(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (coord_feed.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    nxt       = coord_feed.pop_front();
                    in_flight = nxt;
                    s_tdata   <= {nxt.value, nxt.coord, nxt.cluster};
                    s_tuser   <= nxt.cmd;
                    s_tlast   <= nxt.done;
                    s_tvalid  <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted mean with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : mean_monitor
        kcu_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_means.size() == 0)
                begin
                    $error("unexpected result: cluster %0d coord %0d mean %0d",
                           m_tdata[3:0], m_tdata[7:4], $signed(m_tdata[39:8]));
                    error_count++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    means_checked++;
                    if (m_tdata[3:0] !== want.cluster)
                    begin
                        $error("out_cluster: expected %0d, got %0d", want.cluster, m_tdata[3:0]);
                        error_count++;
                    end
                    if (m_tdata[7:4] !== want.coord)
                    begin
                        $error("out_coord: expected %0d, got %0d", want.coord, m_tdata[7:4]);
                        error_count++;
                    end
                    if (m_tdata[39:8] !== want.mean)
                    begin
                        $error("mean_value: expected %0d, got %0d",
                               want.mean, $signed(m_tdata[39:8]));
                        error_count++;
                    end
                    if (m_tuser !== want.empty)
                    begin
                        $error("empty_cluster: expected %0d, got %0d", want.empty, m_tuser);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // Watchdog: count cycles out of reset with no transaction on either side
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("kmeans_centroid_update_core: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic coord_item_t accum_of(input logic [IDX_W-1:0] c,
                                             input logic [IDX_W-1:0] d,
                                             input logic [VALUE_W-1:0] v,
                                             input logic done);
        coord_item_t it;
        it.cmd     = CMD_ACCUMULATE;
        it.cluster = c;
        it.coord   = d;
        it.value   = v;
        it.done    = done;
        return it;
    endfunction

    function automatic coord_item_t read_of(input logic [IDX_W-1:0] c,
                                            input logic [IDX_W-1:0] d);
        coord_item_t it;
        it.cmd     = CMD_READ;
        it.cluster = c;
        it.coord   = d;
        it.value   = $urandom;  // ignored by a read, toggle it anyway
        it.done    = 1'($urandom_range(1));
        return it;
    endfunction

    // Mix of full-range, extreme, small and moderate Q16.16 coordinates
    function automatic logic [VALUE_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return int'($urandom_range(64)) - 32;
            default: return int'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000;
        endcase
    endfunction

    function automatic coord_item_t noise_item();
        coord_item_t it;
        it.cmd     = 1'($urandom_range(1));
        it.cluster = IDX_W'($urandom_range(15));
        it.coord   = IDX_W'($urandom_range(15));
        it.value   = $urandom;
        it.done    = 1'($urandom_range(1));
        return it;
    endfunction

    // Queue one item; hold while the feed is full. Ignored accumulates do not count.
    task automatic push_item(input coord_item_t it);
        while (coord_feed.size() >= FEED_DEPTH)
            @(posedge clk);
        coord_feed.insert(coord_feed.size(), it);
        if (it.cmd == CMD_READ || (it.cluster < in_use(k_reg, KCU_MAX_CLUSTERS)
                                   && it.coord < in_use(d_reg, KCU_MAX_DIMENSIONS)))
            useful_items++;
    endtask

    // Wait for the stream to empty and every mean to arrive, then let the core settle
    task automatic drain_and_settle();
        while (coord_feed.size() != 0 || s_tvalid || expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] k_val,
                                  input logic [CFG_W-1:0] d_val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLUSTERS;
        cfg_data  <= k_val;
        @(posedge clk);
        cfg_index <= CFG_DIMENSIONS;
        cfg_data  <= d_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        k_reg = k_val;
        d_reg = d_val;
        settings_written++;
    endtask

    task automatic set_gaps(input int sender_pct, input int receiver_pct);
        sender_gap_pct   = sender_pct;
        receiver_gap_pct = receiver_pct;
    endtask

    // Mostly whole points and whole-cluster readbacks; the rest broken points and noise
    task automatic random_phase(input int n_useful);
        int k_eff;
        int d_eff;
        int c;
        int d;
        int cut;
        int r;
        int stop_at;
        k_eff   = in_use(k_reg, KCU_MAX_CLUSTERS);
        d_eff   = in_use(d_reg, KCU_MAX_DIMENSIONS);
        stop_at = useful_items + n_useful;
        while (useful_items < stop_at)
        begin
            r = $urandom_range(99);
            // now and then aim at a cluster outside the ones in use
            if ($urandom_range(15) == 0)
                c = $urandom_range(15);
            else
                c = $urandom_range(k_eff - 1);
            if (r < 55)
            begin
                for (d = 0; d < d_eff; d++)
                    push_item(accum_of(IDX_W'(c), IDX_W'(d), pick_coord(), d == d_eff - 1));
            end
            else if (r < 75)
            begin
                for (d = 0; d < d_eff; d++)
                    push_item(read_of(IDX_W'(c), IDX_W'(d)));
            end
            else if (r < 85)
            begin
                push_item(read_of(IDX_W'(c), IDX_W'($urandom_range(15))));
            end
            else if (r < 93)
            begin
                // truncated point with point_done placed at random
                cut = $urandom_range(d_eff - 1);
                for (d = 0; d <= cut; d++)
                    push_item(accum_of(IDX_W'(c), IDX_W'(d), pick_coord(),
                                       1'($urandom_range(1))));
            end
            else
            begin
                push_item(noise_item());
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        foreach (sum_store[j])
            sum_store[j] = '0;
        foreach (point_store[j])
            point_store[j] = '0;

        // Hold reset, then wait out the clearing pass
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);

        // Directed part: three clusters, two dimensions
        set_gaps(24, 66);
        write_settings(5'd3, 5'd2);
        push_item(accum_of(0, 0, 32'h7FFF_FFFF, 1'b0));
        push_item(accum_of(0, 1, 32'h8000_0000, 1'b1));
        push_item(read_of(0, 0));                        // largest mean, no clamp
        push_item(read_of(0, 1));                        // smallest mean, clears count
        push_item(read_of(0, 0));                        // empty cluster
        push_item(accum_of(1, 0, 32'h7FFF_FFFF, 1'b0));
        push_item(accum_of(1, 0, 32'h7FFF_FFFF, 1'b0));
        push_item(accum_of(1, 1, 32'hFFFF_FFFB, 1'b1));
        push_item(read_of(1, 0));                        // mean clamps high
        push_item(accum_of(2, 0, 32'h8000_0000, 1'b0));
        push_item(accum_of(2, 0, 32'h8000_0000, 1'b0));
        push_item(accum_of(2, 0, 32'h8000_0000, 1'b0));
        push_item(accum_of(2, 1, 32'h0000_0007, 1'b1));
        push_item(accum_of(2, 1, 32'hFFFF_FFEC, 1'b1));
        push_item(read_of(2, 0));                        // mean clamps low
        push_item(read_of(2, 1));                        // -13/2 truncates to -6
        push_item(accum_of(3, 0, 32'h0000_0064, 1'b1)); // cluster not in use: dropped
        push_item(accum_of(0, 2, 32'h1234_5678, 1'b1)); // dimension not in use: dropped
        push_item(accum_of(15, 15, 32'hFFFF_FFFF, 1'b1));
        push_item(read_of(0, 1));                        // still empty after the drops
        push_item(read_of(15, 15));                      // read outside the range in use
        push_item(read_of(3, 1));
        push_item(read_of(1, 1));
        push_item(read_of(1, 1));
        drain_and_settle();

        write_settings(5'd5, 5'd3);
        random_phase(170);
        drain_and_settle();

        // Swap the idle ratios; cluster register above its range, one dimension
        set_gaps(66, 24);
        write_settings(5'd31, 5'd1);
        random_phase(170);
        drain_and_settle();

        // Zero in both registers: one cluster, one dimension, back to back.
        // Large positive coordinates then large negative ones, read before and after.
        set_gaps(0, 0);
        write_settings(5'd0, 5'd0);
        push_item(read_of(0, 0));
        for (i = 0; i < 6; i++)
            push_item(accum_of(0, 0, 32'h7FFF_FFFF, 1'b1));
        repeat (4) push_item(accum_of(0, 0, 32'h8000_0000, 1'b1));
        push_item(read_of(0, 0));
        drain_and_settle();

        write_settings(5'd2, 5'd31);
        random_phase(170);
        drain_and_settle();

        write_settings(5'd16, 5'd16);
        random_phase(160);
        drain_and_settle();

        $display("run covered %0d input transactions and %0d checked means",
                 accepted_items, means_checked);
        $display("over %0d register settings, including zero and over-range values",
                 settings_written);
        if (error_count == 0)
            $display("kmeans_centroid_update_core: match");
        else
            $display("kmeans_centroid_update_core: mismatch");
        $finish;
    end

endmodule
